// ----- rtl/core/tfn_pkg.sv -----
// ----------------------------------------------------------------------------
// tfn_pkg: shared types and constants for the triangle face normal block
// Widths of the edge, cross product, root and divider data paths.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int unsigned CoordBits      = 24;
  localparam int unsigned NormalFracBits = 14;
  localparam int unsigned NumComp        = 3;

  localparam int unsigned EdgeW  = CoordBits + 1;          // vertex difference
  localparam int unsigned ProdW  = 2 * EdgeW;              // signed product
  localparam int unsigned MagW   = 2 * CoordBits + 1;      // cross magnitude
  localparam int unsigned LoW    = (MagW + 1) / 2;         // low split of magnitude
  localparam int unsigned HiW    = MagW - LoW;
  localparam int unsigned RadW   = 2 * MagW + 2;           // sum of squares, even
  localparam int unsigned RootW  = RadW / 2;
  localparam int unsigned RemW   = RootW + 2;
  localparam int unsigned SqSteps = RootW;
  localparam int unsigned DivW   = RootW + 1;              // divisor is twice the root
  localparam int unsigned QuoW   = NormalFracBits + 1;
  localparam int unsigned DivSteps = QuoW;
  localparam int unsigned OutW   = 16;
  localparam int unsigned LimitW = 24;

  localparam logic [OutW-1:0] NormalOne = OutW'(1) << NormalFracBits;

  localparam int unsigned PaddrW = 3;
  localparam logic [PaddrW-1:0] AddrDegenLimit = 3'd0;
  localparam logic [LimitW-1:0] DegenLimitRst  = 24'd168;

  // square root cell payload
  typedef struct packed {
    logic [RadW-1:0]             rad;
    logic [RemW-1:0]             rem;
    logic [RootW-1:0]            root;
    logic [NumComp-1:0]          neg;
    logic [NumComp-1:0][MagW-1:0] mag;
  } sq_t;

  // divider cell payload
  typedef struct packed {
    logic [NumComp-1:0][DivW-1:0] rem;
    logic [NumComp-1:0][QuoW-1:0] quo;
    logic [DivW-1:0]              dvs;
    logic [QuoW-1:0]              nlow;
    logic [NumComp-1:0]           neg;
    logic                         degen;
  } dv_t;

endpackage

// ----- rtl/core/tfn_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// tfn_sqrt_cell: one digit of the restoring square root
// Takes two radicand bits, decides one root bit, hands on to the next cell.
// ----------------------------------------------------------------------------
module tfn_sqrt_cell
  import tfn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  sq_t  d_i,
  output logic vld_o,
  output sq_t  q_o
);

  logic        vld_q;
  sq_t         cell_d, cell_q;
  logic [RemW+1:0] rem_t, trial;

  always_comb begin
    rem_t  = {d_i.rem, d_i.rad[RadW-1 -: 2]};
    trial  = {2'b00, d_i.root, 2'b01};
    cell_d = d_i;
    cell_d.rad = d_i.rad << 2;
    if (rem_t >= trial) begin
      cell_d.rem  = RemW'(rem_t - trial);
      cell_d.root = {d_i.root[RootW-2:0], 1'b1};
    end else begin
      cell_d.rem  = rem_t[RemW-1:0];
      cell_d.root = {d_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign vld_o = vld_q;
  assign q_o   = cell_q;

endmodule

// ----- rtl/core/tfn_div_cell.sv -----
// ----------------------------------------------------------------------------
// tfn_div_cell: one quotient bit of the restoring divider, all three lanes
// Shares one divisor across the x, y and z components.
// ----------------------------------------------------------------------------
module tfn_div_cell
  import tfn_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  dv_t  d_i,
  output logic vld_o,
  output dv_t  q_o
);

  logic         vld_q;
  dv_t          cell_d, cell_q;
  logic [DivW:0] t;

  always_comb begin
    cell_d      = d_i;
    cell_d.nlow = d_i.nlow << 1;
    t           = '0;
    for (int c = 0; c < NumComp; c++) begin
      t = {d_i.rem[c], d_i.nlow[QuoW-1]};
      if (t >= {1'b0, d_i.dvs}) begin
        cell_d.rem[c] = DivW'(t - {1'b0, d_i.dvs});
        cell_d.quo[c] = {d_i.quo[c][QuoW-2:0], 1'b1};
      end else begin
        cell_d.rem[c] = t[DivW-1:0];
        cell_d.quo[c] = {d_i.quo[c][QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign vld_o = vld_q;
  assign q_o   = cell_q;

endmodule

// ----- rtl/core/triangle_face_normal.sv -----
// ----------------------------------------------------------------------------
// triangle_face_normal: unit face normal of a triangle, signed Q1.14
// Edges, cross product, squared length, root chain, divider chain.
//
//   port group   dir  contents
//   s_axis_*     in   vertices A, B, C, nine Q11.12 coordinates
//   m_axis_*     out  normal x, y, z in Q1.14, degenerate flag in tuser
//   APB          in   degenerate_limit at byte address 0
//
// One item per cycle while the output is not stalled; stages in order: 5 front
// stages, 50 root cells, 1 limit stage, 15 divider cells, 1 output register.
// The whole pipe advances together; it freezes only while a result is held
// at the output and not taken, so s_axis_tready follows the output side.
// Reset clears all valid bits and loads the limit with 168.
// ----------------------------------------------------------------------------
module triangle_face_normal
  import tfn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz; 24 bits each, lowest first
  input  logic [215:0]      s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // normal_x, normal_y, normal_z; 16 bits each, lowest first
  output logic [47:0]       m_axis_tdata,
  // degenerate
  output logic              m_axis_tuser,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic en;
  logic [LimitW-1:0] limit_q;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign prdata = (paddr == AddrDegenLimit) ? {8'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= DegenLimitRst;
    end else if (psel && penable && pwrite && pready && paddr == AddrDegenLimit) begin
      limit_q <= pwdata[LimitW-1:0];
    end
  end

  // ---------------- front end ----------------
  logic m_vld_q;
  assign en            = !m_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  logic [4:0] fv_q;
  logic signed [EdgeW-1:0] e1_q [NumComp];
  logic signed [EdgeW-1:0] e2_q [NumComp];
  logic signed [ProdW-1:0] p_q [2*NumComp];
  logic [NumComp-1:0]      neg3_q, neg4_q, neg5_q;
  logic [MagW-1:0]         mag3_q [NumComp];
  logic [MagW-1:0]         mag4_q [NumComp];
  logic [MagW-1:0]         mag5_q [NumComp];
  logic [2*LoW-1:0]        pll_q [NumComp];
  logic [HiW+LoW-1:0]      plh_q [NumComp];
  logic [2*HiW-1:0]        phh_q [NumComp];
  logic [RadW-1:0]         sum_q;

  logic signed [CoordBits-1:0] crd [9];
  logic signed [ProdW:0]       ndiff [NumComp];
  logic [ProdW:0]              nabs [NumComp];
  logic [RadW-1:0]             sum_d;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      crd[k] = s_axis_tdata[k*CoordBits +: CoordBits];
    end
    for (int c = 0; c < NumComp; c++) begin
      ndiff[c] = (ProdW+1)'(p_q[2*c]) - (ProdW+1)'(p_q[2*c+1]);
      nabs[c]  = ndiff[c][ProdW] ? (ProdW+1)'(-ndiff[c]) : ndiff[c];
    end
    sum_d = '0;
    for (int c = 0; c < NumComp; c++) begin
      sum_d = sum_d + (RadW'(phh_q[c]) << (2*LoW)) + (RadW'(plh_q[c]) << (LoW+1))
            + RadW'(pll_q[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (en) begin
      fv_q <= {fv_q[3:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < NumComp; c++) begin
        e1_q[c] <= EdgeW'(crd[3+c]) - EdgeW'(crd[c]);
        e2_q[c] <= EdgeW'(crd[6+c]) - EdgeW'(crd[c]);
      end
      p_q[0] <= e1_q[1] * e2_q[2];
      p_q[1] <= e1_q[2] * e2_q[1];
      p_q[2] <= e1_q[2] * e2_q[0];
      p_q[3] <= e1_q[0] * e2_q[2];
      p_q[4] <= e1_q[0] * e2_q[1];
      p_q[5] <= e1_q[1] * e2_q[0];
      for (int c = 0; c < NumComp; c++) begin
        neg3_q[c] <= ndiff[c][ProdW];
        mag3_q[c] <= nabs[c][MagW-1:0];
        pll_q[c]  <= mag3_q[c][LoW-1:0] * mag3_q[c][LoW-1:0];
        plh_q[c]  <= mag3_q[c][MagW-1:LoW] * mag3_q[c][LoW-1:0];
        phh_q[c]  <= mag3_q[c][MagW-1:LoW] * mag3_q[c][MagW-1:LoW];
        mag4_q[c] <= mag3_q[c];
        mag5_q[c] <= mag4_q[c];
      end
      neg4_q <= neg3_q;
      neg5_q <= neg4_q;
      sum_q  <= sum_d;
    end
  end

  // ---------------- square root chain ----------------
  sq_t  sq_d [SqSteps+1];
  logic sq_v [SqSteps+1];
  sq_t  sq0;

  always_comb begin
    sq0.rad  = sum_q;
    sq0.rem  = '0;
    sq0.root = '0;
    sq0.neg  = neg5_q;
    for (int c = 0; c < NumComp; c++) begin
      sq0.mag[c] = mag5_q[c];
    end
  end

  assign sq_d[0] = sq0;
  assign sq_v[0] = fv_q[4];

  for (genvar g = 0; g < SqSteps; g++) begin : g_sqrt
    tfn_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (sq_v[g]),
      .d_i    (sq_d[g]),
      .vld_o  (sq_v[g+1]),
      .q_o    (sq_d[g+1])
    );
  end

  // ---------------- limit check, divider set-up ----------------
  logic [RootW-1:0] len;
  dv_t  dv_d [DivSteps+1];
  logic dv_v [DivSteps+1];
  dv_t  dv0_d, dv0_q;
  logic dv0_v_q;

  assign len = sq_d[SqSteps].root;

  always_comb begin
    dv0_d.dvs   = {len, 1'b0};
    dv0_d.nlow  = len[QuoW-1:0];
    dv0_d.neg   = sq_d[SqSteps].neg;
    dv0_d.degen = (len <= RootW'(limit_q));
    for (int c = 0; c < NumComp; c++) begin
      // numerator is mag * 2^15 + len; its top part seeds the remainder
      dv0_d.rem[c] = DivW'(sq_d[SqSteps].mag[c]) + DivW'(len >> QuoW);
      dv0_d.quo[c] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv0_v_q <= 1'b0;
    end else if (en) begin
      dv0_v_q <= sq_v[SqSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv0_q <= dv0_d;
    end
  end

  assign dv_d[0] = dv0_q;
  assign dv_v[0] = dv0_v_q;

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    tfn_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (dv_v[g]),
      .d_i    (dv_d[g]),
      .vld_o  (dv_v[g+1]),
      .q_o    (dv_d[g+1])
    );
  end

  // ---------------- output register ----------------
  dv_t fin;
  logic [NumComp-1:0][OutW-1:0] comp_d;
  logic [NumComp*OutW-1:0] data_q;
  logic degen_q;

  assign fin = dv_d[DivSteps];

  always_comb begin
    for (int c = 0; c < NumComp; c++) begin
      if (fin.degen) begin
        comp_d[c] = (c == 1) ? NormalOne : '0;
      end else if (fin.neg[c]) begin
        comp_d[c] = OutW'(-{1'b0, fin.quo[c]});
      end else begin
        comp_d[c] = OutW'(fin.quo[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= dv_v[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q  <= comp_d;
      degen_q <= fin.degen;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = degen_q;

  // ---------------- assertions ----------------
  a_degen_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[15:0] == '0 && m_axis_tdata[31:16] == NormalOne
      && m_axis_tdata[47:32] == '0)
    else $error("degenerate item without the up normal");

  a_x_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) <= $signed(NormalOne)
      && $signed(m_axis_tdata[15:0]) >= -$signed(NormalOne))
    else $error("normal x outside unit range");

  a_rem_seed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v[0] && !dv_d[0].degen |->
      dv_d[0].rem[0] < dv_d[0].dvs && dv_d[0].rem[1] < dv_d[0].dvs
      && dv_d[0].rem[2] < dv_d[0].dvs)
    else $error("divider seed not below divisor");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv_v[0]) && $stable(sq_v[SqSteps]))
    else $error("pipe moved while stalled");

endmodule

// ----- verif/triangle_face_normal_tb.sv -----
// ----------------------------------------------------------------------------
// triangle_face_normal_tb: self-checking bench for the triangle face normal
// Directed triangles (axis normals, degenerate limit edges, coordinate
// extremes), then random triangles under several limit settings, with
// random gaps on the input stream and random back-pressure on the output.
// ----------------------------------------------------------------------------
module triangle_face_normal_tb;
  import tfn_pkg::*;

  localparam int unsigned CyclesMax = 600000;
  localparam int unsigned PipeDepth = 72;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned ItemsPerPhase = 330;

  typedef logic signed [23:0] coord_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        degen;
  } normal_t;

  typedef struct {
    coord_t  v[9];
    bit      typed;
    normal_t res;
  } tri_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // ax, ay, az, bx, by, bz, cx, cy, cz; 24 bits each, lowest first
  logic [215:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // normal_x, normal_y, normal_z; 16 bits each, lowest first
  logic [47:0] m_axis_tdata;
  // degenerate
  logic        m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  normal_t     normals_due[$];
  logic [23:0] limit_q = DegenLimitRst;
  int unsigned n_errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;
  bit          no_idle = 1'b0;

  triangle_face_normal i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_cnt, what, got, want);
    n_errors++;
  endtask

  function automatic logic [127:0] isqrt(input logic [127:0] rad);
    logic [127:0] root;
    logic [127:0] bitv;
    root = '0;
    bitv = 128'd1 << 126;
    while (bitv > rad) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rad >= root + bitv) begin
        rad  = rad - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic normal_t face_normal(input coord_t v[9]);
    longint      e1[3], e2[3], cr[3];
    logic [127:0] mag[3], sum, len, q;
    normal_t     r;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(v[3+i]) - longint'(v[i]);
      e2[i] = longint'(v[6+i]) - longint'(v[i]);
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (cr[i] < 0) ? 128'(-cr[i]) : 128'(cr[i]);
      sum += mag[i] * mag[i];
    end
    len = isqrt(sum);
    if (len <= 128'(limit_q)) begin
      r.x = '0; r.y = NormalOne; r.z = '0; r.degen = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      logic [15:0] c;
      q = ((mag[i] << (NormalFracBits + 1)) + len) / (len << 1);
      if (q > 32767) q = 32767;
      c = q[15:0];
      if (cr[i] < 0) c = -c;
      if (i == 0) r.x = c; else if (i == 1) r.y = c; else r.z = c;
    end
    r.degen = 1'b0;
    return r;
  endfunction

  task automatic send_tri(input tri_row_t row);
    bit taken;
    normal_t want;
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    for (int i = 0; i < 9; i++) s_axis_tdata[24*i +: 24] <= row.v[i];
    do begin
      @(negedge clk_i);
      taken = s_axis_tvalid && s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    want = row.typed ? row.res : face_normal(row.v);
    normals_due.push_back(want);
    gap = 0;
    if (!no_idle && $urandom_range(0, 9) >= 6)
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrDegenLimit;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (!wr && prdata[23:0] != limit_q)
      report("degenerate_limit readback", prdata, 32'(limit_q));
    @(posedge clk_i);
    if (wr) limit_q = data[23:0];
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (normals_due.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 8) @(posedge clk_i);
  endtask

  function automatic tri_row_t mk(input int a0, a1, a2, b0, b1, b2, c0, c1, c2);
    tri_row_t r;
    r.v = '{coord_t'(a0), coord_t'(a1), coord_t'(a2), coord_t'(b0), coord_t'(b1),
            coord_t'(b2), coord_t'(c0), coord_t'(c1), coord_t'(c2)};
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic tri_row_t mk_typed(input tri_row_t r, input logic [15:0] x, y, z,
                                        input logic dg);
    r.typed = 1'b1;
    r.res = '{x, y, z, dg};
    return r;
  endfunction

  function automatic tri_row_t rand_tri();
    tri_row_t r;
    int unsigned mode;
    int span;
    mode = $urandom_range(0, 99);
    for (int i = 0; i < 9; i++) r.v[i] = coord_t'($urandom());
    r.typed = 1'b0;
    if (mode < 40) return r;
    // small or tiny triangles near a random corner, some of them collinear
    span = (mode < 70) ? (1 << $urandom_range(2, 16)) : $urandom_range(1, 300);
    for (int i = 0; i < 3; i++) begin
      r.v[i] = coord_t'($urandom_range(0, 8388606 * 2) - 8388607);
      r.v[3+i] = r.v[i] + coord_t'($urandom_range(0, 2 * span) - span);
      if (mode < 85)
        r.v[6+i] = r.v[i] + coord_t'($urandom_range(0, 2 * span) - span);
    end
    if (mode >= 85) begin
      int k;
      k = $urandom_range(0, 4) - 2;
      for (int i = 0; i < 3; i++) r.v[6+i] = r.v[i] + coord_t'(k * (r.v[3+i] - r.v[i]));
    end
    return r;
  endfunction

  // output side: random back-pressure, some long stalls
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CyclesMax) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0:       stall_left <= $urandom_range(10, 50);
        1, 2, 3: m_axis_tready <= 1'b0;
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  // an item seen here is taken at the coming rising edge
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (normals_due.size() == 0) begin
        report("result with nothing pending", m_axis_tdata[31:0], '0);
      end else begin
        normal_t want;
        want = normals_due.pop_front();
        if (m_axis_tdata[15:0] != want.x)
          report("normal_x", 32'(m_axis_tdata[15:0]), 32'(want.x));
        if (m_axis_tdata[31:16] != want.y)
          report("normal_y", 32'(m_axis_tdata[31:16]), 32'(want.y));
        if (m_axis_tdata[47:32] != want.z)
          report("normal_z", 32'(m_axis_tdata[47:32]), 32'(want.z));
        if (m_axis_tuser != want.degen)
          report("degenerate", 32'(m_axis_tuser), 32'(want.degen));
      end
    end
  end

  initial begin
    tri_row_t    rows[$];
    logic [31:0] limits[NumPhases];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(1'b0, '0);

    rows.push_back(mk_typed(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, NormalOne, 0, 1));
    rows.push_back(mk_typed(mk(0, 0, 0, 4096, 0, 0, 0, 4096, 0), 0, 0, 16384, 0));
    rows.push_back(mk_typed(mk(0, 0, 0, 0, 4096, 0, 4096, 0, 0), 0, 0, 16'hc000, 0));
    rows.push_back(mk_typed(mk(0, 0, 0, 0, 0, 4096, 4096, 0, 0), 0, 16384, 0, 0));
    rows.push_back(mk_typed(mk(0, 0, 0, 0, 4096, 0, 0, 0, 4096), 16384, 0, 0, 0));
    rows.push_back(mk_typed(mk(0, 0, 0, 1, 0, 0, 0, 1, 0), 0, NormalOne, 0, 1));
    rows.push_back(mk_typed(mk(7, 7, 7, 175, 7, 7, 7, 8, 7), 0, NormalOne, 0, 1));
    rows.push_back(mk_typed(mk(7, 7, 7, 176, 7, 7, 7, 8, 7), 0, 0, 16384, 0));
    rows.push_back(mk_typed(mk(0, 0, 0, 1000, 2000, 3000, 2000, 4000, 6000),
                            0, NormalOne, 0, 1));
    rows.push_back(mk_typed(mk(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                               -8388608, -8388608, -8388608), 0, NormalOne, 0, 1));
    rows.push_back(mk(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                      8388607, -8388608, 8388607));
    rows.push_back(mk(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                      -8388608, 8388607, -8388608));
    rows.push_back(mk(8388607, -8388608, 0, -8388608, 8388607, 8388607,
                      0, 8388607, -8388608));
    rows.push_back(mk(0, 0, 0, 3, 0, 0, 1, 7, 5));
    rows.push_back(mk(-1, -1, -1, 4095, 12, -3, 17, -4096, 8191));
    rows.push_back(mk(100, -200, 300, 101, -199, 301, 99, -200, 302));
    foreach (rows[i]) send_tri(rows[i]);
    drain();

    limits = '{32'd0, 32'hff_ffff, $urandom_range(1, 16777214), 32'd168,
               $urandom_range(0, 4000), $urandom() & 32'hff_ffff};
    for (int p = 0; p < NumPhases; p++) begin
      apb_access(1'b1, limits[p]);
      apb_access(1'b0, '0);
      no_idle = (p == 2);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (p == 3 && n == ItemsPerPhase / 2) begin
          s_axis_tvalid <= 1'b0;
          while (normals_due.size() != 0) @(posedge clk_i);
        end
        send_tri(rand_tri());
      end
      drain();
    end
    no_idle = 1'b0;

    if (n_errors == 0 && normals_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tfn_pkg.sv
rtl/core/tfn_sqrt_cell.sv
rtl/core/tfn_div_cell.sv
rtl/core/triangle_face_normal.sv
verif/triangle_face_normal_tb.sv
